[design/dqe_pkg.sv]
// Shared constants, types and helpers for the DNS question name encoder.
`timescale 1ns / 1ps
package dqe_pkg;

  localparam int unsigned MAX_LABEL_DEF = 63;
  localparam logic [7:0]  DOT_CHAR      = 8'd46;
  localparam logic [9:0]  NAME_LEN_MAX  = 10'h3FF;
  localparam logic [9:0]  CAP_RESET     = 10'd500;
  localparam int unsigned APB_AW        = 2;
  localparam logic [APB_AW-1:0] REG_CAP_ADDR = '0;

  typedef enum logic {
    CMD_CHAR   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  function automatic logic [7:0] tail_byte(input logic [2:0] idx,
                                           input logic [15:0] qtype,
                                           input logic [15:0] qclass);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      3'd1:    b = qtype[15:8];
      3'd2:    b = qtype[7:0];
      3'd3:    b = qclass[15:8];
      3'd4:    b = qclass[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

[design/dns_qname_encoder_top.sv]
// Top level of the DNS question name encoder with its label memory.
`timescale 1ns / 1ps
// Builds a DNS question body from a host name fed one item per character.
// Input channel (in_valid_i/in_ready_o): command_i selects a name character
// or finish; query_type_i and query_class_i are used on finish only.
// Output channel (out_valid_o/out_ready_i): up to two body bytes per item,
// with is_last_o on the final item of a question and error_o on a failed one.
// A character item yields nothing; it is written into the label memory
// unless the label is full. A dot or finish item first reads the label
// memory and then gives one result per cycle unless stalled, up to two
// bytes each, since the label memory has two read ports; a label of L bytes
// plus its length byte leaves in ceil((L+1)/2) results, and finish adds the
// terminator and the type and class words. A new item is taken once the
// last result of the previous one sits in the output register. While the
// receiver stalls, the output register holds its item and emission pauses.
// Reset clears the question state and sets body_capacity to 500; the label
// memory needs no clearing. body_capacity is an APB register at address 0.
module dns_qname_encoder_top #(
  parameter int unsigned MaxLabel = dqe_pkg::MAX_LABEL_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [7:0]                name_char_i,
  input  logic [15:0]               query_type_i,
  input  logic [15:0]               query_class_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                first_byte_o,
  output logic [7:0]                second_byte_o,
  output logic [1:0]                byte_count_o,
  output logic                      is_last_o,
  output logic                      error_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dqe_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned LW = $clog2(MaxLabel + 1);
  localparam int unsigned AW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;
  localparam int unsigned PW = $clog2(MaxLabel + 8);

  dqe_pkg::state_e state_q, state_d;

  logic [7:0]    label_mem [MaxLabel];
  logic [7:0]    rd_a_q, rd_b_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  logic [LW-1:0] label_len_q, label_len_d;
  logic [9:0]    name_len_q, name_len_d;
  logic          err_q, err_d;
  logic [9:0]    cap_q;

  logic [LW-1:0] em_len_q, em_len_d;
  logic [PW-1:0] em_base_q, em_base_d;
  logic [PW-1:0] em_total_q, em_total_d;
  logic          em_fin_q, em_fin_d;
  logic          em_err_q, em_err_d;
  logic [15:0]   qtype_q, qtype_d;
  logic [15:0]   qclass_q, qclass_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          pend_q, pend_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_b0_q, out_b0_d;
  logic [7:0]    out_b1_q, out_b1_d;
  logic [1:0]    out_cnt_q, out_cnt_d;
  logic          out_last_q, out_last_d;
  logic          out_err_q, out_err_d;

  logic          in_fire, out_free;
  logic [9:0]    name_inc;
  logic          over_chr, over_fin, err_chr;
  logic          cnt2, done;
  logic [PW-1:0] pos_next;
  logic [7:0]    b0, b1;

  function automatic logic [7:0] pick(input logic [PW-1:0] q, input logic [7:0] rd,
                                      input logic [PW-1:0] base, input logic [LW-1:0] len,
                                      input logic [15:0] qt, input logic [15:0] qc);
    logic [PW-1:0] t;
    logic [7:0]    b;
    t = q - base;
    if (q < base) begin
      b = (q == '0) ? 8'(len) : rd;
    end else begin
      b = dqe_pkg::tail_byte(t[2:0], qt, qc);
    end
    return b;
  endfunction

  assign in_ready_o = (state_q == dqe_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign name_inc = (name_len_q != dqe_pkg::NAME_LEN_MAX) ? name_len_q + 10'd1 : name_len_q;
  assign over_chr = ({1'b0, name_inc} + 11'd5) >= {1'b0, cap_q};
  assign over_fin = ({1'b0, name_len_q} + 11'd5) >= {1'b0, cap_q};
  assign err_chr  = err_q || over_chr;

  assign cnt2     = (em_total_q - pos_q) >= PW'(2);
  assign pos_next = pos_q + (cnt2 ? PW'(2) : PW'(1));
  assign done     = pos_next >= em_total_q;
  assign b0 = pick(pos_q, rd_a_q, em_base_q, em_len_q, qtype_q, qclass_q);
  assign b1 = pick(pos_q + PW'(1), rd_b_q, em_base_q, em_len_q, qtype_q, qclass_q);

  assign rd_addr_a = (rd_pos >= PW'(1) && rd_pos <= PW'(MaxLabel)) ? AW'(rd_pos - PW'(1)) : '0;
  assign rd_addr_b = (rd_pos < PW'(MaxLabel)) ? AW'(rd_pos) : '0;
  assign wr_addr   = AW'(label_len_q);

  always_comb begin
    state_d     = state_q;
    label_len_d = label_len_q;
    name_len_d  = name_len_q;
    err_d       = err_q;
    em_len_d    = em_len_q;
    em_base_d   = em_base_q;
    em_total_d  = em_total_q;
    em_fin_d    = em_fin_q;
    em_err_d    = em_err_q;
    qtype_d     = qtype_q;
    qclass_d    = qclass_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_b0_d    = out_b0_q;
    out_b1_d    = out_b1_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_pos      = pos_q;

    unique case (state_q)
      dqe_pkg::ST_IDLE: begin
        if (in_fire) begin
          pos_d  = '0;
          pend_d = 1'b0;
          if (command_i == dqe_pkg::CMD_FINISH) begin
            em_err_d    = err_q || over_fin;
            em_fin_d    = 1'b1;
            em_len_d    = label_len_q;
            em_base_d   = (label_len_q != '0) ? PW'(label_len_q) + PW'(1) : '0;
            em_total_d  = ((label_len_q != '0) ? PW'(label_len_q) + PW'(1) : '0) + PW'(5);
            qtype_d     = query_type_i;
            qclass_d    = query_class_i;
            label_len_d = '0;
            name_len_d  = '0;
            err_d       = 1'b0;
            state_d     = dqe_pkg::ST_EMIT;
          end else begin
            name_len_d = name_inc;
            err_d      = err_chr;
            if (name_char_i == dqe_pkg::DOT_CHAR) begin
              if (!err_chr) begin
                em_err_d    = 1'b0;
                em_fin_d    = 1'b0;
                em_len_d    = label_len_q;
                em_base_d   = PW'(label_len_q) + PW'(1);
                em_total_d  = PW'(label_len_q) + PW'(1);
                label_len_d = '0;
                state_d     = dqe_pkg::ST_EMIT;
              end
            end else if (label_len_q >= LW'(MaxLabel)) begin
              err_d = 1'b1;
            end else begin
              wr_en       = 1'b1;
              label_len_d = label_len_q + LW'(1);
            end
          end
        end
      end
      dqe_pkg::ST_EMIT: begin
        if (em_err_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_b0_d    = 8'd0;
            out_b1_d    = 8'd0;
            out_cnt_d   = 2'd0;
            out_last_d  = 1'b1;
            out_err_d   = 1'b1;
            state_d     = dqe_pkg::ST_IDLE;
          end
        end else if (!pend_q) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_b0_d    = b0;
          out_b1_d    = cnt2 ? b1 : 8'd0;
          out_cnt_d   = cnt2 ? 2'd2 : 2'd1;
          out_last_d  = em_fin_q && done;
          out_err_d   = 1'b0;
          pos_d       = pos_next;
          if (done) begin
            pend_d  = 1'b0;
            state_d = dqe_pkg::ST_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_pos = pos_next;
          end
        end
      end
      default: state_d = dqe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      label_mem[wr_addr] <= name_char_i;
    end
    if (rd_en) begin
      rd_a_q <= label_mem[rd_addr_a];
      rd_b_q <= label_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqe_pkg::ST_IDLE;
      label_len_q <= '0;
      name_len_q  <= '0;
      err_q       <= 1'b0;
      cap_q       <= dqe_pkg::CAP_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      label_len_q <= label_len_d;
      name_len_q  <= name_len_d;
      err_q       <= err_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && paddr == dqe_pkg::REG_CAP_ADDR) begin
        cap_q <= pwdata[9:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    em_len_q   <= em_len_d;
    em_base_q  <= em_base_d;
    em_total_q <= em_total_d;
    em_fin_q   <= em_fin_d;
    em_err_q   <= em_err_d;
    qtype_q    <= qtype_d;
    qclass_q   <= qclass_d;
    pos_q      <= pos_d;
    out_b0_q   <= out_b0_d;
    out_b1_q   <= out_b1_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign first_byte_o  = out_b0_q;
  assign second_byte_o = out_b1_q;
  assign byte_count_o  = out_cnt_q;
  assign is_last_o     = out_last_q;
  assign error_o       = out_err_q;

  assign prdata = (paddr == dqe_pkg::REG_CAP_ADDR) ? {22'd0, cap_q} : 32'd0;
  assign pready = 1'b1;

endmodule

[design/dqe_checker.sv]
// Port-level assertions for the DNS question name encoder and their binding.
`timescale 1ns / 1ps
module dqe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] first_byte_o,
  input logic [7:0] second_byte_o,
  input logic [1:0] byte_count_o,
  input logic       is_last_o,
  input logic       error_o
);

  // An empty item is only ever the final error report of a question.
  a_empty_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == 2'd0 |-> error_o && is_last_o)
    else $error("empty item without error report");

  // An error report carries no bytes.
  a_error_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> byte_count_o == 2'd0 && first_byte_o == 8'd0)
    else $error("error report carries bytes");

  // The unused second byte reads as zero.
  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o != 2'd2 |-> second_byte_o == 8'd0)
    else $error("second byte not zero");

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_byte_o)
      && $stable(byte_count_o) && $stable(is_last_o))
    else $error("stalled item changed");

endmodule

bind dns_qname_encoder_top dqe_checker u_dqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .first_byte_o  (first_byte_o),
  .second_byte_o (second_byte_o),
  .byte_count_o  (byte_count_o),
  .is_last_o     (is_last_o),
  .error_o       (error_o)
);

[dv/dns_qname_encoder_top_tb.sv]
// Self-checking testbench for the DNS question name encoder top level.
`timescale 1ns / 1ps
module dns_qname_encoder_top_tb;

  localparam int unsigned SETTLE      = 40;
  localparam int unsigned RX_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned PLAN_ROWS   = 29;
  localparam logic [7:0]  DOT         = dqe_pkg::DOT_CHAR;

  typedef struct packed {
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic [1:0] count;
    logic       last;
    logic       err;
  } body_word_t;

  typedef struct packed {
    logic          cfg;
    logic [9:0]    cap;
    dqe_pkg::cmd_e cmd;
    logic [7:0]    ch;
    logic [15:0]   qt;
    logic [15:0]   qc;
    logic          typed;
    body_word_t    res;
  } row_t;

  localparam body_word_t NO_WORD          = '0;
  localparam body_word_t EMPTY_LABEL_WORD = '{8'h00, 8'h00, 2'd1, 1'b0, 1'b0};
  localparam body_word_t A_LABEL_WORD     = '{8'h01, 8'h61, 2'd2, 1'b0, 1'b0};
  localparam body_word_t LIMIT_WORD       = '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1};

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         command_i;
  logic [7:0]                   name_char_i;
  logic [15:0]                  query_type_i;
  logic [15:0]                  query_class_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [7:0]                   first_byte_o;
  logic [7:0]                   second_byte_o;
  logic [1:0]                   byte_count_o;
  logic                         is_last_o;
  logic                         error_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dqe_pkg::APB_AW-1:0]   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  // Encoder shadow state.
  logic [7:0]  label_mem [dqe_pkg::MAX_LABEL_DEF];
  int unsigned label_len;
  logic [9:0]  name_cnt;
  logic        limit_hit;
  logic [9:0]  cap_reg;

  body_word_t  step_words [$];
  body_word_t  pending_words [$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned words_checked = 0;
  int unsigned limit_reports = 0;
  int unsigned cap_settings = 1;
  int unsigned cycle_cnt = 0;
  logic        tx_burst = 1'b0;
  logic        rx_burst = 1'b0;
  logic        rx_hold_req = 1'b0;

  row_t plan [PLAN_ROWS] = '{
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'hFFFF, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   DOT,   16'h0000, 16'h0000, 1'b1, EMPTY_LABEL_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "a",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   DOT,   16'hFFFF, 16'hFFFF, 1'b1, A_LABEL_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   8'h00, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   8'hFF, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   DOT,   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   8'h55, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   8'hAA, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h0000, 16'hFFFF, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "x",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   DOT,   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h1234, 16'hABCD, 1'b0, NO_WORD},
    '{1'b1, 10'd6,    dqe_pkg::CMD_CHAR,   8'h00, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "q",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   DOT,   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h0000, 16'h0000, 1'b1, LIMIT_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h5A5A, 16'hA5A5, 1'b0, NO_WORD},
    '{1'b1, 10'd7,    dqe_pkg::CMD_CHAR,   8'h00, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "q",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h0001, 16'h8000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "q",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "r",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h0000, 16'h0000, 1'b1, LIMIT_WORD},
    '{1'b1, 10'd1023, dqe_pkg::CMD_CHAR,   8'h00, 16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "w",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   DOT,   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_CHAR,   "z",   16'h0000, 16'h0000, 1'b0, NO_WORD},
    '{1'b0, 10'd0,    dqe_pkg::CMD_FINISH, 8'h00, 16'h8000, 16'h0001, 1'b0, NO_WORD}
  };

  dns_qname_encoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .name_char_i   (name_char_i),
    .query_type_i  (query_type_i),
    .query_class_i (query_class_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .byte_count_o  (byte_count_o),
    .is_last_o     (is_last_o),
    .error_o       (error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic void clear_question();
    foreach (label_mem[i]) label_mem[i] = 8'h00;
    label_len = 0;
    name_cnt  = '0;
    limit_hit = 1'b0;
  endfunction

  function automatic logic over_capacity();
    return ({22'd0, name_cnt} + 32'd5) >= {22'd0, cap_reg};
  endfunction

  // Works out the body words that one accepted item produces.
  function automatic void encode_item(dqe_pkg::cmd_e cmd, logic [7:0] ch, logic [15:0] qt,
                                      logic [15:0] qc);
    logic [7:0]  body [dqe_pkg::MAX_LABEL_DEF + 6];
    int unsigned n;
    int unsigned pos;
    int unsigned cnt;
    logic        final_step;
    body_word_t  w;
    step_words.delete();
    n = 0;
    final_step = (cmd == dqe_pkg::CMD_FINISH);
    if (cmd == dqe_pkg::CMD_FINISH) begin
      if (over_capacity()) limit_hit = 1'b1;
      if (limit_hit) begin
        step_words.push_back(LIMIT_WORD);
        clear_question();
        return;
      end
      if (label_len > 0) begin
        body[0] = label_len[7:0];
        for (int i = 0; i < label_len; i++) body[1 + i] = label_mem[i];
        n = 1 + label_len;
      end
      body[n]     = 8'h00;
      body[n + 1] = qt[15:8];
      body[n + 2] = qt[7:0];
      body[n + 3] = qc[15:8];
      body[n + 4] = qc[7:0];
      n = n + 5;
      clear_question();
    end else begin
      if (name_cnt != dqe_pkg::NAME_LEN_MAX) name_cnt = name_cnt + 10'd1;
      if (over_capacity()) limit_hit = 1'b1;
      if (ch == dqe_pkg::DOT_CHAR) begin
        if (limit_hit) return;
        body[0] = label_len[7:0];
        for (int i = 0; i < label_len; i++) body[1 + i] = label_mem[i];
        n = 1 + label_len;
        label_len = 0;
      end else begin
        if (label_len >= dqe_pkg::MAX_LABEL_DEF) begin
          limit_hit = 1'b1;
        end else begin
          label_mem[label_len] = ch;
          label_len++;
        end
        return;
      end
    end
    pos = 0;
    while (pos < n) begin
      cnt = (n - pos >= 2) ? 2 : 1;
      w.first_b  = body[pos];
      w.second_b = (cnt == 2) ? body[pos + 1] : 8'h00;
      w.count    = cnt[1:0];
      w.last     = final_step && (pos + cnt >= n);
      w.err      = 1'b0;
      step_words.push_back(w);
      pos += cnt;
    end
  endfunction

  task automatic send_item(dqe_pkg::cmd_e cmd, logic [7:0] ch, logic [15:0] qt,
                           logic [15:0] qc, logic typed, body_word_t res);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    name_char_i   <= ch;
    query_type_i  <= qt;
    query_class_i <= qc;
    do @(posedge clk_i); while (!in_ready_o);
    encode_item(cmd, ch, qt, qc);
    if (typed) begin
      pending_words.push_back(res);
    end else begin
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    end
    items_sent++;
  endtask

  // Waits until the block is idle, then writes and reads back the capacity.
  task automatic set_capacity(logic [9:0] v);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= dqe_pkg::REG_CAP_ADDR;
    pwdata  <= {22'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[9:0] !== v || pready !== 1'b1) begin
      flag_mismatch($sformatf("capacity read back %0d, wrote %0d", prdata[9:0], v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cap_reg = v;
    cap_settings++;
  endtask

  // end_dot: 0 never closes the last label with a dot, 1 always, else at random.
  task automatic send_question(int unsigned labels, int unsigned min_len,
                               int unsigned max_len, int unsigned end_dot,
                               logic strays);
    int unsigned len;
    logic [7:0]  ch;
    logic [15:0] qt;
    logic [15:0] qc;
    logic        dot;
    for (int unsigned l = 0; l < labels; l++) begin
      len = $urandom_range(min_len, max_len);
      for (int unsigned k = 0; k < len; k++) begin
        ch = 8'($urandom_range(0, 255));
        if (ch == dqe_pkg::DOT_CHAR && !(strays && $urandom_range(0, 3) == 0)) ch = ch + 8'd1;
        send_item(dqe_pkg::CMD_CHAR, ch, 16'($urandom), 16'($urandom), 1'b0, NO_WORD);
      end
      if (l + 1 < labels) dot = 1'b1;
      else if (end_dot == 0) dot = 1'b0;
      else if (end_dot == 1) dot = 1'b1;
      else dot = ($urandom_range(0, 3) == 0);
      if (dot) begin
        send_item(dqe_pkg::CMD_CHAR, dqe_pkg::DOT_CHAR, 16'($urandom), 16'($urandom), 1'b0,
                  NO_WORD);
      end
    end
    qt = 16'($urandom);
    qc = 16'($urandom);
    if ($urandom_range(0, 7) == 0) qt = 16'hFFFF;
    if ($urandom_range(0, 7) == 0) qc = 16'h0000;
    send_item(dqe_pkg::CMD_FINISH, 8'($urandom), qt, qc, 1'b0, NO_WORD);
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 15);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    body_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (error_o === 1'b1) limit_reports++;
      if (pending_words.size() == 0) begin
        flag_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_words.pop_front();
        if (first_byte_o !== want.first_b)
          flag_mismatch($sformatf("first_byte %h, expected %h", first_byte_o, want.first_b));
        if (second_byte_o !== want.second_b)
          flag_mismatch($sformatf("second_byte %h, expected %h", second_byte_o,
                                  want.second_b));
        if (byte_count_o !== want.count)
          flag_mismatch($sformatf("byte_count %0d, expected %0d", byte_count_o, want.count));
        if (is_last_o !== want.last)
          flag_mismatch($sformatf("is_last %b, expected %b", is_last_o, want.last));
        if (error_o !== want.err)
          flag_mismatch($sformatf("error %b, expected %b", error_o, want.err));
      end
    end
  end

  initial begin
    int unsigned base;
    int unsigned waited;
    logic [9:0]  cap;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = dqe_pkg::CMD_CHAR;
    name_char_i   = 8'h00;
    query_type_i  = 16'h0000;
    query_class_i = 16'h0000;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = 32'd0;
    cap_reg       = dqe_pkg::CAP_RESET;
    clear_question();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].cfg) begin
        set_capacity(plan[r].cap);
      end else begin
        send_item(plan[r].cmd, plan[r].ch, plan[r].qt, plan[r].qc, plan[r].typed,
                  plan[r].res);
      end
    end

    // A full-length label closed by a dot.
    send_question(1, 63, 63, 1, 1'b0);

    for (int unsigned phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       cap = 10'($urandom_range(6, 30));
        1:       cap = 10'd1023;
        2:       cap = 10'($urandom_range(31, 1022));
        3:       cap = 10'($urandom_range(6, 18));
        4:       cap = dqe_pkg::CAP_RESET;
        default: cap = 10'($urandom_range(6, 1023));
      endcase
      set_capacity(cap);
      tx_burst = (phase == 2);
      rx_burst = (phase == 2) || (phase == 4);
      if (phase == 1) begin
        // The receiver stalls for a long stretch while names keep coming.
        rx_hold_req = 1'b1;
        tx_burst = 1'b1;
        send_question(2, 3, 4, 1, 1'b0);
        tx_burst = 1'b0;
      end
      base = items_sent;
      while (items_sent - base < 4) begin
        send_question($urandom_range(0, 3), 0, $urandom_range(1, 5), 2, 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", pending_words.size()));
    end

    $display("Sent %0d items and checked %0d results under %0d capacity settings.",
             items_sent, words_checked, cap_settings);
    $display("Finish results that reported a limit error: %0d.", limit_reports);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
